>>> hw/rtl/plcdb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plcdb_pkg: shared types and constants for the power level block
// Q14 stage factors, Q24 dB steps, log offset and sequencer state codes
// ----------------------------------------------------------------------------
package plcdb_pkg;

    localparam int ENERGY_W = 32;
    localparam int LEVEL_W  = 15;
    localparam int M_W      = 31;  // running value never exceeds the positive input
    localparam int NEXT_W   = 32;  // (m >> 14) * factor stays below 2^32
    localparam int OPA_W    = 17;
    localparam int FAC_W    = 15;
    localparam int SUM_W    = 33;
    localparam int Q14_SH   = 14;
    localparam int SUM_SH   = 17;
    localparam int OUT_SH   = 7;

    localparam logic [M_W-1:0]          SWITCH_LEVEL = M_W'(65536);
    localparam logic signed [SUM_W-1:0] LOG_OFFSET   = -33'sd1531392380;
    localparam logic signed [22:0]      PCT_SCALE    = 23'sd100;

    localparam logic [1:0] STAGE_DBL   = 2'd0;
    localparam logic [1:0] STAGE_TENTH = 2'd1;
    localparam logic [1:0] STAGE_HUND  = 2'd2;
    localparam logic [1:0] STAGE_THOU  = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DBL   = 5'b00010,
        S_MUL   = 5'b00100,
        S_CMP   = 5'b01000,
        S_SCALE = 5'b10000
    } t_state;

    function automatic logic [FAC_W-1:0] stage_factor(input logic [1:0] stage);
        logic [FAC_W-1:0] f;
        case (stage)
            STAGE_TENTH: f = 15'd18022;
            STAGE_HUND:  f = 15'd16548;
            STAGE_THOU:  f = 15'd16400;
            default:     f = 15'd0;
        endcase
        return f;
    endfunction

    function automatic logic signed [SUM_W-1:0] db_step(input logic [1:0] stage);
        logic signed [SUM_W-1:0] d;
        case (stage)
            STAGE_DBL:   d = 33'sd50504453;
            STAGE_TENTH: d = 33'sd6944540;
            STAGE_HUND:  d = 33'sd725006;
            STAGE_THOU:  d = 33'sd72826;
            default:     d = '0;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/power_level_log_centidb.sv
// sequence: doubling steps first, then a multiply and a compare per step in each of
// the tenth, hundredth and thousandth stages, then scaling into the result register
// throughput: one transaction at a time, next input taken once the result
// is registered; the Q14 multiplier and its compare set the per-step cost
// reset: synchronous active-low i_rst_n clears the sequencer and output valid
`default_nettype none
// ----------------------------------------------------------------------------
// power_level_log_centidb: signal level in hundredths of a dB
// multiplicative normalization of a running value against the energy input,
// one shared 17x15 multiplier under a small sequencer, dB steps accumulated
// ----------------------------------------------------------------------------
module power_level_log_centidb
    import plcdb_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic signed [ENERGY_W-1:0] i_energy,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic signed [LEVEL_W-1:0]      o_level_centidb
);

    t_state                    r_state, n_state;
    logic [1:0]                r_stage, n_stage;
    logic signed [ENERGY_W-1:0] r_x, n_x;
    logic [M_W-1:0]            r_m, n_m;
    logic [NEXT_W-1:0]         r_next, n_next;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic signed [LEVEL_W-1:0] r_level, n_level;
    logic                      r_out_valid, n_out_valid;

    logic                      big;
    logic [OPA_W-1:0]          mul_a;
    logic [NEXT_W-1:0]         prod;
    logic [NEXT_W-1:0]         q14_next;
    logic [NEXT_W-1:0]         cand;
    logic                      fits;
    logic                      grows;
    logic signed [15:0]        lvl_t;
    logic signed [22:0]        lvl_t100;

    // shared Q14 multiplier: truncation rule switches above 65536
    assign big      = r_m > SWITCH_LEVEL;
    assign mul_a    = big ? r_m[M_W-1:Q14_SH] : r_m[OPA_W-1:0];
    assign prod     = NEXT_W'(mul_a) * NEXT_W'(stage_factor(r_stage));
    assign q14_next = big ? prod : (prod >> Q14_SH);

    // candidate for the compare: doubled value or the registered product
    assign cand  = (r_state == S_DBL) ? {r_m, 1'b0} : r_next;
    assign fits  = $signed({1'b0, cand}) <= $signed({r_x[ENERGY_W-1], r_x});
    assign grows = cand > NEXT_W'(r_m);

    // floor shifts on a signed sum are arithmetic shifts
    assign lvl_t    = r_sum[SUM_W-1:SUM_SH];
    assign lvl_t100 = $signed({{7{lvl_t[15]}}, lvl_t}) * PCT_SCALE;

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_level_centidb = r_level;

    always_comb begin
        n_state     = r_state;
        n_stage     = r_stage;
        n_x         = r_x;
        n_m         = r_m;
        n_next      = r_next;
        n_sum       = r_sum;
        n_level     = r_level;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_x     = i_energy;
                    n_m     = M_W'(1);
                    n_sum   = LOG_OFFSET;
                    n_stage = STAGE_DBL;
                    n_state = S_DBL;
                end
            end
            S_DBL: begin
                if (fits && grows) begin
                    n_m   = cand[M_W-1:0];
                    n_sum = r_sum + db_step(r_stage);
                end else begin
                    n_stage = STAGE_TENTH;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_next  = q14_next;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (fits && grows) begin
                    n_m     = cand[M_W-1:0];
                    n_sum   = r_sum + db_step(r_stage);
                    n_state = S_MUL;
                end else if (r_stage == STAGE_THOU) begin
                    n_state = S_SCALE;
                end else begin
                    n_stage = r_stage + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_SCALE: begin
                // wait until the previous result has left the output register
                if (!r_out_valid || i_out_ready) begin
                    n_level     = lvl_t100[21:OUT_SH];
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stage     <= STAGE_DBL;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_stage     <= n_stage;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_m     <= n_m;
        r_next  <= n_next;
        r_sum   <= n_sum;
        r_level <= n_level;
    end

endmodule
`default_nettype wire
